[rtl/sle_pkg.sv]
// Shared types and constants for the sequential list engine.
// Holds the command and status codes, the transfer payload structs,
// the sequencer states and the memory request bundle. No dependencies.
package sle_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [2:0] CMD_POP_BACK   = 3'd2;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [2:0] CMD_INSERT     = 3'd4;
  localparam logic [2:0] CMD_ERASE      = 3'd5;
  localparam logic [2:0] CMD_FIND       = 3'd6;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_BADPOS   = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [4:0]         position;
    logic signed [31:0] value;
  } req_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [IDX_W-1:0] found_index;
    logic [CNT_W-1:0] count_after;
  } rsp_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOVE_UP,
    S_MOVE_DOWN,
    S_SETTLE,
    S_PLACE,
    S_SCAN,
    S_REPORT
  } seq_state_t;

  typedef struct packed {
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic [IDX_W-1:0]      raddr;
  } mem_req_t;

endpackage

[rtl/sle_mem.sv]
// Entry store of the list: one write port and one registered read port.
// Depends on sle_pkg for the depth, word width and request bundle.
module sle_mem (
  input  logic                          clk,
  input  sle_pkg::mem_req_t             req,
  output logic [sle_pkg::DATA_WIDTH-1:0] rd_data
);
  import sle_pkg::*;

  logic [DATA_WIDTH-1:0] entries [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      entries[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= entries[req.raddr];
  end

endmodule

[rtl/sequential_list_engine_top.sv]
// Sequential list engine: an ordered list of up to CAPACITY words kept in a
// single-port-write, registered-read memory. One command is handled at a time.
// Pop back, every error, the unused code, find on an empty list, and pop
// front or erase of the last entry go straight to the result. Push back and
// insert at the end write the new word at once; insert and push front at a
// position below the count first move the entries from there up one place,
// pop front and erase of any other entry move the entries above it down one
// place, and find reads the entries from index 0 until one matches.
// The memory port moves or reads one entry per cycle, so the work grows with
// the entries moved or read. A finished result waits in the output register
// while the next command is taken. Depends on sle_pkg and sle_mem.
module sequential_list_engine_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  sle_pkg::req_item_t req_data,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output sle_pkg::rsp_item_t rsp_data
);
  import sle_pkg::*;

  seq_state_t            state, state_next;
  logic [CNT_W-1:0]      count, count_next;
  logic [IDX_W-1:0]      ptr, ptr_next;
  logic [IDX_W-1:0]      at, at_next;
  logic [DATA_WIDTH-1:0] word, word_next;
  logic                  is_open, is_open_next;
  logic                  wr_pend, wr_pend_next;
  logic [IDX_W-1:0]      wr_addr, wr_addr_next;
  logic                  cmp_pend, cmp_pend_next;
  logic [IDX_W-1:0]      cmp_idx, cmp_idx_next;
  logic                  issued_all, issued_all_next;
  logic [2:0]            res_status, res_status_next;
  logic [IDX_W-1:0]      res_found, res_found_next;
  logic                  rsp_load;

  logic [CNT_W-1:0]      count_dec;
  logic [CNT_W-1:0]      at_c;
  logic                  accept;
  mem_req_t              mem_req;
  logic [DATA_WIDTH-1:0] rd_data;

  sle_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  assign count_dec = count - CNT_W'(1);
  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      wr_pend   <= 1'b0;
      cmp_pend  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      wr_pend  <= wr_pend_next;
      cmp_pend <= cmp_pend_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    at         <= at_next;
    word       <= word_next;
    is_open    <= is_open_next;
    wr_addr    <= wr_addr_next;
    cmp_idx    <= cmp_idx_next;
    issued_all <= issued_all_next;
    res_status <= res_status_next;
    res_found  <= res_found_next;
    if (rsp_load) begin
      rsp_data.status      <= res_status;
      rsp_data.found_index <= res_found;
      rsp_data.count_after <= count;
    end
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    ptr_next        = ptr;
    at_next         = at;
    word_next       = word;
    is_open_next    = is_open;
    wr_pend_next    = wr_pend;
    wr_addr_next    = wr_addr;
    cmp_pend_next   = cmp_pend;
    cmp_idx_next    = cmp_idx;
    issued_all_next = issued_all;
    res_status_next = res_status;
    res_found_next  = res_found;
    rsp_load        = 1'b0;
    at_c            = '0;
    mem_req.we      = 1'b0;
    mem_req.waddr   = wr_addr;
    mem_req.wdata   = rd_data;
    mem_req.raddr   = ptr;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          word_next       = req_data.value[DATA_WIDTH-1:0];
          res_status_next = ST_OK;
          res_found_next  = '0;
          wr_pend_next    = 1'b0;
          cmp_pend_next   = 1'b0;
          issued_all_next = 1'b0;
          state_next      = S_REPORT;
          unique case (req_data.cmd)
            CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_INSERT: begin
              is_open_next = 1'b1;
              if (req_data.cmd == CMD_PUSH_BACK) begin
                at_c = count;
              end else if (req_data.cmd == CMD_PUSH_FRONT) begin
                at_c = '0;
              end else begin
                at_c = req_data.position;
              end
              if (count >= CNT_W'(CAPACITY)) begin
                res_status_next = ST_FULL;
              end else if (req_data.cmd == CMD_INSERT && req_data.position > count) begin
                res_status_next = ST_BADPOS;
              end else begin
                at_next = at_c[IDX_W-1:0];
                if (at_c == count) begin
                  state_next = S_PLACE;
                end else begin
                  ptr_next   = count_dec[IDX_W-1:0];
                  state_next = S_MOVE_UP;
                end
              end
            end
            CMD_POP_BACK: begin
              if (count == '0) begin
                res_status_next = ST_EMPTY;
              end else begin
                count_next = count_dec;
              end
            end
            CMD_POP_FRONT, CMD_ERASE: begin
              is_open_next = 1'b0;
              at_c = (req_data.cmd == CMD_ERASE) ? req_data.position : '0;
              if (count == '0) begin
                res_status_next = ST_EMPTY;
              end else if (at_c >= count) begin
                res_status_next = ST_BADPOS;
              end else if (at_c == count_dec) begin
                // last entry goes, nothing to move
                count_next = count_dec;
              end else begin
                ptr_next   = at_c[IDX_W-1:0] + IDX_W'(1);
                state_next = S_MOVE_DOWN;
              end
            end
            CMD_FIND: begin
              res_status_next = ST_NOTFOUND;
              if (count != '0) begin
                ptr_next   = '0;
                state_next = S_SCAN;
              end
            end
            default: begin
              state_next = S_REPORT;
            end
          endcase
        end
      end

      S_MOVE_UP: begin
        // write the entry read last cycle one place higher, read the next lower one
        mem_req.we   = wr_pend;
        wr_pend_next = 1'b1;
        wr_addr_next = ptr + IDX_W'(1);
        if (ptr == at) begin
          state_next = S_SETTLE;
        end else begin
          ptr_next = ptr - IDX_W'(1);
        end
      end

      S_MOVE_DOWN: begin
        mem_req.we   = wr_pend;
        wr_pend_next = 1'b1;
        wr_addr_next = ptr - IDX_W'(1);
        if ({1'b0, ptr} == count_dec) begin
          state_next = S_SETTLE;
        end else begin
          ptr_next = ptr + IDX_W'(1);
        end
      end

      S_SETTLE: begin
        mem_req.we   = wr_pend;
        wr_pend_next = 1'b0;
        if (is_open) begin
          state_next = S_PLACE;
        end else begin
          count_next = count_dec;
          state_next = S_REPORT;
        end
      end

      S_PLACE: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = at;
        mem_req.wdata = word;
        count_next    = count + CNT_W'(1);
        state_next    = S_REPORT;
      end

      S_SCAN: begin
        if (cmp_pend && rd_data == word) begin
          res_status_next = ST_OK;
          res_found_next  = cmp_idx;
          cmp_pend_next   = 1'b0;
          state_next      = S_REPORT;
        end else if (issued_all) begin
          cmp_pend_next = 1'b0;
          state_next    = S_REPORT;
        end else begin
          cmp_pend_next = 1'b1;
          cmp_idx_next  = ptr;
          if ({1'b0, ptr} == count_dec) begin
            issued_all_next = 1'b1;
          end else begin
            ptr_next = ptr + IDX_W'(1);
          end
        end
      end

      S_REPORT: begin
        // hold until the output register is free
        if (!rsp_valid || !rsp_stall) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
